>>> rtl/sc3f_pkg.sv
package sc3f_pkg;

    localparam int ACC_W = 38;
    localparam int PROD_W = 36;
    localparam int V_W = 20;
    localparam int OUT_W = 24;
    localparam int COEF_W = 16;
    localparam int SAMPLE_W = 16;
    localparam int RW_W = 11;
    localparam int ADDR_W = 5;

    localparam logic signed [ACC_W-1:0] ACC_RND = ACC_W'(2048);

    localparam logic [2:0] REG_CX0 = 3'd0;
    localparam logic [2:0] REG_CX1 = 3'd1;
    localparam logic [2:0] REG_CX2 = 3'd2;
    localparam logic [2:0] REG_CY0 = 3'd3;
    localparam logic [2:0] REG_CY1 = 3'd4;
    localparam logic [2:0] REG_CY2 = 3'd5;
    localparam logic [2:0] REG_MODE = 3'd6;
    localparam logic [2:0] REG_WIDTH = 3'd7;

    localparam logic [1:0] MODE_BOTH = 2'd0;
    localparam logic [1:0] MODE_HORZ = 2'd1;
    localparam logic [1:0] MODE_VERT = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_MAC  = 7'b0000100,
        S_VSAT = 7'b0001000,
        S_SEL  = 7'b0010000,
        S_HSAT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    function automatic logic signed [V_W-1:0] rnd_sat20(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = (a + ACC_RND) >>> 12;
        if (t > ACC_W'(524287)) begin
            return 20'sh7FFFF;
        end else if (t < -ACC_W'(524288)) begin
            return 20'sh80000;
        end
        return t[V_W-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] rnd_sat24(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = (a + ACC_RND) >>> 12;
        if (t > ACC_W'(8388607)) begin
            return 24'sh7FFFFF;
        end else if (t < -ACC_W'(8388608)) begin
            return 24'sh800000;
        end
        return t[OUT_W-1:0];
    endfunction

endpackage

>>> rtl/sc3f_ram.sv
module sc3f_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/separable_conv3_filter_unit.sv
// separable 3x3 convolution over a row-major pixel stream
//
// input channel: i_in_valid / o_in_stall with i_sample and i_frame_start.
// a request is taken when i_in_valid is high and o_in_stall is low.
// output channel: o_out_valid / i_out_stall with o_out_value and o_row_end.
// configuration: apb-style port, eight 32-bit registers at byte offset 4*i.
//
// one request is in flight at a time. the two previous rows sit in one
// line memory (old and mid side by side), read at acceptance and written
// back in the read state that follows. a single 16x20 multiplier steps
// through the taps: a vertical pass unless the mode is horizontal-only,
// then a horizontal pass when a horizontal result is due and the mode is
// not vertical-only. in horizontal-only mode the first two columns of a
// row skip the multiplier. the next request is taken once back in idle.
// if the output register is still held by a stalled receiver, the block
// waits in its last step until the result is taken, and meanwhile takes no
// new request. reset clears position, row count, window and the output
// valid flag and restores the default registers; the line memory is not
// cleared and needs no setup time.
module separable_conv3_filter_unit
    import sc3f_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_frame_start,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [OUT_W-1:0]    o_out_value,
    output logic                       o_row_end,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);

    // configuration registers
    logic signed [COEF_W-1:0] r_cx0, r_cx1, r_cx2, r_cy0, r_cy1, r_cy2;
    logic [1:0]               r_mode;
    logic [RW_W-1:0]          r_row_width;
    logic                     cfg_we;
    logic [2:0]               cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx0       <= -16'sd4096;
            r_cx1       <= '0;
            r_cx2       <= 16'sd4096;
            r_cy0       <= -16'sd4096;
            r_cy1       <= '0;
            r_cy2       <= 16'sd4096;
            r_mode      <= MODE_BOTH;
            r_row_width <= RW_W'(1024);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_CX0:   r_cx0 <= pwdata[COEF_W-1:0];
                REG_CX1:   r_cx1 <= pwdata[COEF_W-1:0];
                REG_CX2:   r_cx2 <= pwdata[COEF_W-1:0];
                REG_CY0:   r_cy0 <= pwdata[COEF_W-1:0];
                REG_CY1:   r_cy1 <= pwdata[COEF_W-1:0];
                REG_CY2:   r_cy2 <= pwdata[COEF_W-1:0];
                REG_MODE:  r_mode <= pwdata[1:0];
                REG_WIDTH: r_row_width <= pwdata[RW_W-1:0];
                default:   r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_CX0:   prdata = 32'(r_cx0);
            REG_CX1:   prdata = 32'(r_cx1);
            REG_CX2:   prdata = 32'(r_cx2);
            REG_CY0:   prdata = 32'(r_cy0);
            REG_CY1:   prdata = 32'(r_cy1);
            REG_CY2:   prdata = 32'(r_cy2);
            REG_MODE:  prdata = 32'(r_mode);
            REG_WIDTH: prdata = 32'(r_row_width);
            default:   prdata = '0;
        endcase
    end

    // effective width and mode
    logic [CW-1:0] width_eff;
    logic          is_horz, is_vert;

    always_comb begin
        if (int'(r_row_width) < 3) begin
            width_eff = CW'(3);
        end else if (int'(r_row_width) > MAX_WIDTH) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = CW'(r_row_width);
        end
    end

    assign is_horz = (r_mode == MODE_HORZ);
    assign is_vert = (r_mode == MODE_VERT);

    // control and position state
    t_state         r_state, n_state;
    logic [AW-1:0]  r_col;
    logic [1:0]     r_rows;
    logic [1:0]     r_tap;
    logic           r_hpass;
    logic           r_emit;
    logic           r_ovalid;
    logic signed [V_W-1:0] r_w0, r_w1;

    // payload
    logic signed [SAMPLE_W-1:0] r_sample, r_old, r_mid;
    logic signed [V_W-1:0]      r_v;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [OUT_W-1:0]    r_h, r_oval;
    logic                       r_last, r_olast;

    logic          in_acc;
    logic          commit;
    logic [AW-1:0] col_base, col_acc;
    logic [1:0]    rows_base, rows_acc;
    logic [CW-1:0] col_ext, col_inc;
    logic          h_needed, v_emit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign commit      = (r_state == S_OUT) && (!r_emit || !r_ovalid || !i_out_stall);
    assign o_out_valid = r_ovalid;
    assign o_out_value = r_oval;
    assign o_row_end   = r_olast;

    // position at acceptance, wrapping if the width was lowered mid-row
    always_comb begin
        col_base  = i_frame_start ? '0 : r_col;
        rows_base = i_frame_start ? 2'd0 : r_rows;
        col_acc   = col_base;
        rows_acc  = rows_base;
        if (CW'(col_base) >= width_eff) begin
            col_acc  = '0;
            rows_acc = (rows_base < 2'd2) ? rows_base + 2'd1 : rows_base;
        end
    end

    assign col_ext  = CW'(r_col);
    assign col_inc  = col_ext + CW'(1);
    assign h_needed = (col_ext >= CW'(2)) && (is_horz || r_rows == 2'd2);
    assign v_emit   = (r_rows == 2'd2) && (col_ext <= width_eff - CW'(3));

    // line memory: upper half old row, lower half mid row
    logic [2*SAMPLE_W-1:0] ram_rdata;
    logic                  ram_we;

    assign ram_we = (r_state == S_READ);

    sc3f_ram #(
        .WIDTH(2 * SAMPLE_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_col),
        .i_wdata({ram_rdata[SAMPLE_W-1:0], r_sample}),
        .i_raddr(col_acc),
        .o_rdata(ram_rdata)
    );

    // shared multiplier operand selection
    logic signed [COEF_W-1:0] mul_coef;
    logic signed [V_W-1:0]    mul_opnd;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        case (r_tap)
            2'd0: begin
                mul_coef = r_hpass ? r_cx0 : r_cy0;
                mul_opnd = r_hpass ? r_w0 : V_W'(r_old);
            end
            2'd1: begin
                mul_coef = r_hpass ? r_cx1 : r_cy1;
                mul_opnd = r_hpass ? r_w1 : V_W'(r_mid);
            end
            default: begin
                mul_coef = r_hpass ? r_cx2 : r_cy2;
                mul_opnd = r_hpass ? r_v : V_W'(r_sample);
            end
        endcase
    end

    assign mul_p = mul_coef * mul_opnd;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_READ;
            S_READ: n_state = is_horz ? S_SEL : S_MAC;
            S_MAC:  if (r_tap == 2'd3) n_state = r_hpass ? S_HSAT : S_VSAT;
            S_VSAT: n_state = S_SEL;
            S_SEL: begin
                if (!is_vert && h_needed) begin
                    n_state = S_MAC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_HSAT: n_state = S_OUT;
            S_OUT:  if (commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_col    <= '0;
            r_rows   <= 2'd0;
            r_tap    <= 2'd0;
            r_hpass  <= 1'b0;
            r_emit   <= 1'b0;
            r_ovalid <= 1'b0;
            r_w0     <= '0;
            r_w1     <= '0;
        end else begin
            r_state <= n_state;
            if (commit && r_emit) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_col  <= col_acc;
                        r_rows <= rows_acc;
                    end
                end
                S_READ: begin
                    r_tap   <= 2'd0;
                    r_hpass <= 1'b0;
                end
                S_MAC: r_tap <= r_tap + 2'd1;
                S_SEL: begin
                    r_tap   <= 2'd0;
                    r_hpass <= 1'b1;
                    r_emit  <= is_vert ? v_emit : h_needed;
                end
                S_OUT: begin
                    if (commit) begin
                        r_w0 <= r_w1;
                        r_w1 <= r_v;
                        if (col_inc >= width_eff) begin
                            r_col  <= '0;
                            r_rows <= (r_rows < 2'd2) ? r_rows + 2'd1 : r_rows;
                        end else begin
                            r_col <= col_inc[AW-1:0];
                        end
                    end
                end
                default: r_tap <= r_tap;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= i_sample;
        end
        if (r_state == S_READ) begin
            r_old <= ram_rdata[2*SAMPLE_W-1:SAMPLE_W];
            r_mid <= ram_rdata[SAMPLE_W-1:0];
            if (is_horz) begin
                r_v <= V_W'(r_sample);
            end
        end
        if (r_state == S_MAC) begin
            if (r_tap != 2'd3) begin
                r_prod <= mul_p;
            end
            if (r_tap == 2'd1) begin
                r_acc <= ACC_W'(r_prod);
            end else if (r_tap != 2'd0) begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
        if (r_state == S_VSAT) begin
            r_v <= rnd_sat20(r_acc);
        end
        if (r_state == S_SEL) begin
            r_h    <= OUT_W'(r_v);
            r_last <= (col_ext == width_eff - CW'(3));
        end
        if (r_state == S_HSAT) begin
            r_h    <= rnd_sat24(r_acc);
            r_last <= (col_ext == width_eff - CW'(1));
        end
        if (commit && r_emit) begin
            r_oval  <= r_h;
            r_olast <= r_last;
        end
    end

endmodule

>>> verif/separable_conv3_filter_unit_tb.sv
`timescale 1ns / 1ps

module separable_conv3_filter_unit_tb
    import sc3f_pkg::*;
;

    localparam int MAX_W = 1024;
    localparam int PRIMED_W = 24;
    localparam int WIDTH_REG_MAX = (1 << RW_W) - 1;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_LIMIT = 100;
    localparam logic [1:0] MODE_ALIAS_BOTH = 2'd3;

    typedef struct {
        logic signed [OUT_W-1:0] out_value;
        logic                    row_end;
    } t_filt_result;

    typedef enum int {
        STALL_NONE,
        STALL_EVEN,
        STALL_RARE,
        STALL_HEAVY
    } t_stall_pattern;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample;
    logic                       i_frame_start;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [OUT_W-1:0]    o_out_value;
    logic                       o_row_end;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    // register mirror and filter state
    logic signed [COEF_W-1:0]   coef_x_cfg [3] = '{-4096, 0, 4096};
    logic signed [COEF_W-1:0]   coef_y_cfg [3] = '{-4096, 0, 4096};
    logic [1:0]                 mode_cfg = MODE_BOTH;
    logic [RW_W-1:0]            width_cfg = RW_W'(MAX_W);
    logic signed [SAMPLE_W-1:0] line_old [MAX_W] = '{default: '0};
    logic signed [SAMPLE_W-1:0] line_mid [MAX_W] = '{default: '0};
    logic signed [V_W-1:0]      vwin [2] = '{default: '0};
    int                         col_pos = 0;
    int                         rows_done = 0;

    logic [2:0] coef_regs [6] = '{REG_CX0, REG_CX1, REG_CX2, REG_CY0, REG_CY1, REG_CY2};

    t_filt_result expected_pixels [$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    int           burst_left = 0;
    bit           hold_off_pending = 1'b0;
    bit           hold_off_active = 1'b0;

    separable_conv3_filter_unit DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint clamp_signed(input longint x, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            return hi;
        end else if (x < lo) begin
            return lo;
        end
        return x;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_pixel();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        return SAMPLE_W'($urandom);
    endfunction

    function automatic int draw_coef();
        case ($urandom_range(0, 3))
            0: begin
                return $urandom_range(0, 1) ? 32767 : -32768;
            end
            1: begin
                return int'($urandom_range(0, 8192)) - 4096;
            end
            2: begin
                return int'($urandom_range(0, 1024)) - 512;
            end
            default: begin
                return int'(signed'(16'($urandom)));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // one accepted pixel through the filter, queues the output it produces
    task automatic filter_pixel(input logic signed [SAMPLE_W-1:0] smp, input logic fs);
        int           w;
        int           c;
        logic [1:0]   md;
        longint       acc;
        longint       vv;
        longint       hh;
        bit           emit;
        bit           last;
        t_filt_result res;
        w = int'(width_cfg);
        if (w < 3) begin
            w = 3;
        end
        if (w > MAX_W) begin
            w = MAX_W;
        end
        md = (mode_cfg == MODE_ALIAS_BOTH) ? MODE_BOTH : mode_cfg;
        emit = 1'b0;
        last = 1'b0;
        hh = 0;
        if (fs) begin
            col_pos = 0;
            rows_done = 0;
        end
        if (col_pos >= w) begin
            col_pos = 0;
            if (rows_done < 2) begin
                rows_done++;
            end
        end
        c = col_pos;
        if (md == MODE_HORZ) begin
            vv = smp;
        end else begin
            acc = longint'(coef_y_cfg[0]) * longint'(line_old[c])
                + longint'(coef_y_cfg[1]) * longint'(line_mid[c])
                + longint'(coef_y_cfg[2]) * longint'(smp);
            vv = clamp_signed((acc + 2048) >>> 12, V_W);
        end
        line_old[c] = line_mid[c];
        line_mid[c] = smp;
        if (md == MODE_VERT) begin
            if (rows_done >= 2 && c <= w - 3) begin
                emit = 1'b1;
                hh = vv;
                last = (c == w - 3);
            end
        end else if (c >= 2 && (md == MODE_HORZ || rows_done >= 2)) begin
            acc = longint'(coef_x_cfg[0]) * longint'(vwin[0])
                + longint'(coef_x_cfg[1]) * longint'(vwin[1])
                + longint'(coef_x_cfg[2]) * vv;
            hh = clamp_signed((acc + 2048) >>> 12, OUT_W);
            emit = 1'b1;
            last = (c == w - 1);
        end
        vwin[0] = vwin[1];
        vwin[1] = V_W'(vv);
        col_pos = c + 1;
        if (col_pos >= w) begin
            col_pos = 0;
            if (rows_done < 2) begin
                rows_done++;
            end
        end
        if (emit) begin
            res.out_value = OUT_W'(hh);
            res.row_end = last;
            expected_pixels.push_back(res);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input int data);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx) inside
            REG_CX0, REG_CX1, REG_CX2: begin
                coef_x_cfg[idx - REG_CX0] = data[15:0];
            end
            REG_CY0, REG_CY1, REG_CY2: begin
                coef_y_cfg[idx - REG_CY0] = data[15:0];
            end
            REG_MODE: begin
                mode_cfg = data[1:0];
            end
            REG_WIDTH: begin
                width_cfg = data[RW_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_pixel(input logic signed [SAMPLE_W-1:0] smp, input logic fs);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sample <= smp;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        filter_pixel(smp, fs);
    endtask

    task automatic send_stream(input int count, input bit new_frame, input bit noise);
        int   i;
        logic fs;
        for (i = 0; i < count; i++) begin
            fs = (i == 0 && new_frame) || (noise && $urandom_range(0, 63) == 0);
            send_pixel(draw_pixel(), fs);
        end
    endtask

    // block idle: no request offered, all outputs in, pipeline flushed
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // horizontal only at reset taps, fills both line stores for narrow rows
    task automatic test_line_priming();
        settle();
        write_reg(REG_MODE, MODE_HORZ);
        write_reg(REG_WIDTH, PRIMED_W);
        send_stream(2 * PRIMED_W, 1'b1, 1'b0);
    endtask

    task automatic test_corner_values();
        logic signed [SAMPLE_W-1:0] corner_pixels [12];
        int i;
        corner_pixels = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
                          16'sh0000, 16'shFFFF, 16'sh0001, 16'sh7FFF, 16'sh7FFF, 16'sh8000};
        settle();
        write_reg(REG_CX0, -32768);
        write_reg(REG_CX1, 32767);
        write_reg(REG_CX2, -32768);
        write_reg(REG_CY0, 32767);
        write_reg(REG_CY1, -32768);
        write_reg(REG_CY2, 32767);
        write_reg(REG_MODE, MODE_BOTH);
        write_reg(REG_WIDTH, 3);
        for (i = 0; i < 12; i++) begin
            send_pixel(corner_pixels[i], i == 0);
        end
        // vertical only, rows already counted
        settle();
        write_reg(REG_MODE, MODE_VERT);
        write_reg(REG_WIDTH, 4);
        for (i = 0; i < 6; i++) begin
            send_pixel(corner_pixels[11 - i], 1'b0);
        end
        // mode three acts as both passes, width zero clamps to three
        settle();
        write_reg(REG_MODE, MODE_ALIAS_BOTH);
        write_reg(REG_WIDTH, 0);
        for (i = 0; i < 6; i++) begin
            send_pixel(corner_pixels[2 * i], 1'b0);
        end
    endtask

    task automatic test_wide_row();
        int r;
        settle();
        for (r = 0; r < 3; r++) begin
            write_reg(coef_regs[r], draw_coef());
        end
        write_reg(REG_MODE, MODE_HORZ);
        write_reg(REG_WIDTH, MAX_W);
        send_stream(MAX_W + 6, 1'b1, 1'b0);
    endtask

    // width lowered while column is past the new row end
    task automatic test_row_shrink();
        settle();
        write_reg(REG_MODE, MODE_BOTH);
        write_reg(REG_WIDTH, 4);
        send_stream(6, 1'b0, 1'b0);
    endtask

    task automatic test_output_holdoff();
        settle();
        write_reg(REG_MODE, MODE_HORZ);
        write_reg(REG_WIDTH, 8);
        hold_off_pending = 1'b1;
        while (!hold_off_active) @(posedge i_clk);
        burst_left = 40;
        send_stream(40, 1'b1, 1'b0);
    endtask

    task automatic test_random_settings(input int phases);
        int         p;
        int         r;
        int         n;
        int         wval;
        int         eff;
        logic [1:0] md;
        for (p = 0; p < phases; p++) begin
            settle();
            md = 2'($urandom_range(0, 3));
            write_reg(REG_MODE, md);
            for (r = 0; r < 6; r++) begin
                if ($urandom_range(0, 2) == 0) begin
                    write_reg(coef_regs[r], draw_coef());
                end
            end
            if (md == MODE_HORZ && $urandom_range(0, 3) == 0) begin
                wval = $urandom_range(PRIMED_W + 1, WIDTH_REG_MAX);
                n = $urandom_range(4, 30);
            end else begin
                wval = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                   : $urandom_range(3, PRIMED_W);
                eff = (wval < 3) ? 3 : wval;
                n = eff * $urandom_range(2, 4) + $urandom_range(0, eff - 1);
            end
            write_reg(REG_WIDTH, wval);
            send_stream(n, $urandom_range(0, 3) != 0, 1'b1);
        end
    endtask

    initial begin : out_stall_driver
        t_stall_pattern pattern;
        int             span;
        i_out_stall = 1'b0;
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_off_active = 1'b1;
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_off_active = 1'b0;
            end
            pattern = t_stall_pattern'($urandom_range(0, 3));
            span = $urandom_range(8, 60);
            repeat (span) begin
                @(negedge i_clk);
                case (pattern)
                    STALL_NONE: begin
                        i_out_stall <= 1'b0;
                    end
                    STALL_EVEN: begin
                        i_out_stall <= ($urandom_range(0, 1) == 1);
                    end
                    STALL_RARE: begin
                        i_out_stall <= ($urandom_range(0, 7) == 0);
                    end
                    default: begin
                        i_out_stall <= ($urandom_range(0, 3) != 0);
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        t_filt_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("output %0d with none expected", o_out_value));
            end else begin
                want = expected_pixels.pop_front();
                if (o_out_value !== want.out_value) begin
                    report_mismatch($sformatf("out_value %0d, expected %0d",
                                              o_out_value, want.out_value));
                end
                if (o_row_end !== want.row_end) begin
                    report_mismatch($sformatf("row_end %0b, expected %0b",
                                              o_row_end, want.row_end));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("separable_conv3_filter_unit regression: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_sample = '0;
        i_frame_start = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_line_priming();
        test_corner_values();
        test_wide_row();
        test_row_shrink();
        test_output_holdoff();
        test_random_settings(10);
        settle();
        if (mismatch_count == 0) begin
            $display("separable_conv3_filter_unit regression: pass");
        end else begin
            $display("separable_conv3_filter_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sc3f_pkg.sv
rtl/sc3f_ram.sv
rtl/separable_conv3_filter_unit.sv
verif/separable_conv3_filter_unit_tb.sv
